// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the voxel face quad emitter RTL.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property must hold at every rising edge outside reset.
`define VFQE_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// Condition must never be true outside reset.
`define VFQE_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) else $error(msg);
`else
`define VFQE_ASSERT(lbl, clk, rstn, prop, msg)
`define VFQE_NEVER(lbl, clk, rstn, cond, msg)
`endif

`endif

// ----- rtl/core/vfqe_pkg.sv -----
// Package for the voxel face quad emitter: constants, control word types,
// microcode program and per-face tables. No dependencies.
package vfqe_pkg;

  localparam int CHUNK_SIDE = 16;
  localparam int CHUNK_TALL = 256;

  localparam int NUM_FACES = 6;
  localparam int UCODE_LEN = 10;
  localparam int PC_W      = 4;

  localparam logic KIND_VERTEX = 1'b0;
  localparam logic KIND_INDEX  = 1'b1;

  localparam logic JMP_STEP = 1'b0;  // fall through to pc+1
  localparam logic JMP_FACE = 1'b1;  // next visible face or end of run

  typedef struct packed {
    logic       kind;
    logic [2:0] sel;   // corner number or triangle slot
    logic       jmp;
  } cw_t;

  typedef struct packed {
    logic       busy;
    logic       kind;
    logic [2:0] sel;
    logic [2:0] face;
    logic       face_end;
    logic       last;
  } seq_ctl_t;

  // Program: four vertex steps, six index steps, jump on the last one.
  function automatic cw_t ucode(input logic [PC_W-1:0] pc);
    cw_t w;
    case (pc)
      4'd0:    w = '{kind: KIND_VERTEX, sel: 3'd0, jmp: JMP_STEP};
      4'd1:    w = '{kind: KIND_VERTEX, sel: 3'd1, jmp: JMP_STEP};
      4'd2:    w = '{kind: KIND_VERTEX, sel: 3'd2, jmp: JMP_STEP};
      4'd3:    w = '{kind: KIND_VERTEX, sel: 3'd3, jmp: JMP_STEP};
      4'd4:    w = '{kind: KIND_INDEX,  sel: 3'd0, jmp: JMP_STEP};
      4'd5:    w = '{kind: KIND_INDEX,  sel: 3'd1, jmp: JMP_STEP};
      4'd6:    w = '{kind: KIND_INDEX,  sel: 3'd2, jmp: JMP_STEP};
      4'd7:    w = '{kind: KIND_INDEX,  sel: 3'd3, jmp: JMP_STEP};
      4'd8:    w = '{kind: KIND_INDEX,  sel: 3'd4, jmp: JMP_STEP};
      4'd9:    w = '{kind: KIND_INDEX,  sel: 3'd5, jmp: JMP_FACE};
      default: w = '{kind: KIND_INDEX,  sel: 3'd5, jmp: JMP_FACE};
    endcase
    return w;
  endfunction

  // Lowest set face in the mask (front first).
  function automatic logic [2:0] first_face(input logic [NUM_FACES-1:0] m);
    logic [2:0] f;
    f = 3'd0;
    for (int i = NUM_FACES - 1; i >= 0; i--) begin
      if (m[i]) f = 3'(i);
    end
    return f;
  endfunction

  // Corner code packing: {v, u, dz, dy, dx}
  function automatic logic [4:0] crn(input logic dx, input logic dy, input logic dz,
                                     input logic u, input logic v);
    return {v, u, dz, dy, dx};
  endfunction

  function automatic logic [4:0] corner_code(input logic [2:0] face, input logic [1:0] k);
    logic [4:0] c;
    case ({face, k})
      5'b000_00: c = crn(0, 0, 1, 0, 0);
      5'b000_01: c = crn(1, 0, 1, 1, 0);
      5'b000_10: c = crn(1, 1, 1, 1, 1);
      5'b000_11: c = crn(0, 1, 1, 0, 1);
      5'b001_00: c = crn(0, 0, 0, 1, 0);
      5'b001_01: c = crn(1, 0, 0, 0, 0);
      5'b001_10: c = crn(1, 1, 0, 0, 1);
      5'b001_11: c = crn(0, 1, 0, 1, 1);
      5'b010_00: c = crn(1, 0, 0, 1, 0);
      5'b010_01: c = crn(1, 1, 0, 1, 1);
      5'b010_10: c = crn(1, 1, 1, 0, 1);
      5'b010_11: c = crn(1, 0, 1, 0, 0);
      5'b011_00: c = crn(0, 0, 0, 0, 0);
      5'b011_01: c = crn(0, 1, 0, 0, 1);
      5'b011_10: c = crn(0, 1, 1, 1, 1);
      5'b011_11: c = crn(0, 0, 1, 1, 0);
      5'b100_00: c = crn(0, 1, 1, 0, 0);
      5'b100_01: c = crn(1, 1, 1, 1, 0);
      5'b100_10: c = crn(1, 1, 0, 1, 1);
      5'b100_11: c = crn(0, 1, 0, 0, 1);
      5'b101_00: c = crn(0, 0, 1, 0, 0);
      5'b101_01: c = crn(1, 0, 1, 0, 1);
      5'b101_10: c = crn(1, 0, 0, 1, 1);
      5'b101_11: c = crn(0, 0, 0, 1, 0);
      default:   c = 5'd0;
    endcase
    return c;
  endfunction

  // Triangle index offsets; odd faces use the reversed winding.
  function automatic logic [1:0] tri_off(input logic odd, input logic [2:0] k);
    logic [1:0] o;
    case ({odd, k})
      4'b0_000: o = 2'd0;
      4'b0_001: o = 2'd1;
      4'b0_010: o = 2'd3;
      4'b0_011: o = 2'd1;
      4'b0_100: o = 2'd2;
      4'b0_101: o = 2'd3;
      4'b1_000: o = 2'd0;
      4'b1_001: o = 2'd3;
      4'b1_010: o = 2'd2;
      4'b1_011: o = 2'd0;
      4'b1_100: o = 2'd2;
      4'b1_101: o = 2'd1;
      default:  o = 2'd0;
    endcase
    return o;
  endfunction

endpackage

// ----- rtl/core/voxel_face_quad_emitter.sv -----
// Top level of the voxel face quad emitter: voxel capture, quad counter,
// record datapath and output register. Depends on vfqe_pkg, vfqe_sequencer
// and assert_macros.svh.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+----------------------------------
//  in_     | input     | in_valid / in_ready   | chunk_start, cell xyz, id, mask
//  out_    | output    | out_valid / out_ready | one vertex or index record
//
// Flow: a voxel is accepted, then each visible face emits one record per cycle
//   while the output is not stalled, from the ten-word control ROM (4 vertex,
//   6 index steps). The input is held until the last record is loaded; empty
//   or out-of-chunk voxels are accepted and emit nothing.
// Stalls: a record waits in the output register, holding the step counter
//   until out_ready. in_ready rises once the last record is loaded.
// Reset: quad counter to zero, sequencer idle, output register empty.
`include "assert_macros.svh"

module voxel_face_quad_emitter (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_chunk_start,
  input  logic [3:0]  in_cell_x,
  input  logic [7:0]  in_cell_y,
  input  logic [3:0]  in_cell_z,
  input  logic [7:0]  in_block_id,
  input  logic [5:0]  in_face_mask,

  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_record_kind,
  output logic [4:0]  out_vert_x,
  output logic [8:0]  out_vert_y,
  output logic [4:0]  out_vert_z,
  output logic [2:0]  out_face_code,
  output logic        out_tex_u,
  output logic        out_tex_v,
  output logic [7:0]  out_vertex_block_id,
  output logic [20:0] out_index_value,
  output logic        out_last_of_run
);

  vfqe_pkg::seq_ctl_t ctl;

  logic in_accept;
  logic voxel_live;  // accepted voxel that actually has faces to emit
  logic advance;     // sequencer emits one record this cycle

  // captured voxel
  logic [3:0] cx_r;
  logic [7:0] cy_r;
  logic [3:0] cz_r;
  logic [7:0] bid_r;

  // running quad counter (wraps modulo 2^19)
  logic [18:0] qc_r, qc_nxt;

  // output register
  logic        out_valid_r, out_valid_nxt;
  logic        kind_r;
  logic [4:0]  vx_r;
  logic [8:0]  vy_r;
  logic [4:0]  vz_r;
  logic [2:0]  fc_r;
  logic        u_r;
  logic        v_r;
  logic [7:0]  obid_r;
  logic [20:0] idx_r;
  logic        last_r;

  logic [4:0]  corner;
  logic [1:0]  toff;

  assign in_ready  = !ctl.busy;
  assign in_accept = in_valid && in_ready;

  // Empty voxel, no faces, or a cell outside the chunk: nothing to emit.
  assign voxel_live = in_accept && (in_block_id != 8'd0) && (in_face_mask != 6'd0) &&
                      (int'(in_cell_x) < vfqe_pkg::CHUNK_SIDE) &&
                      (int'(in_cell_z) < vfqe_pkg::CHUNK_SIDE) &&
                      (int'(in_cell_y) < vfqe_pkg::CHUNK_TALL);

  // One record per step whenever the output register is free or draining.
  assign advance = ctl.busy && (!out_valid_r || out_ready);

  vfqe_sequencer u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (voxel_live),
    .start_mask (in_face_mask),
    .advance    (advance),
    .ctl        (ctl)
  );

  always_ff @(posedge clk) begin
    if (voxel_live) begin
      cx_r  <= in_cell_x;
      cy_r  <= in_cell_y;
      cz_r  <= in_cell_z;
      bid_r <= in_block_id;
    end
  end

  // chunk_start clears even on an empty voxel; count bumps at each face end
  always_comb begin
    qc_nxt = qc_r;
    if (in_accept && in_chunk_start) begin
      qc_nxt = '0;
    end else if (advance && ctl.face_end) begin
      qc_nxt = qc_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qc_r <= '0;
    end else begin
      qc_r <= qc_nxt;
    end
  end

  assign corner = vfqe_pkg::corner_code(ctl.face, ctl.sel[1:0]);
  assign toff   = vfqe_pkg::tri_off(ctl.face[0], ctl.sel);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Record payload; fields unused by the record kind are forced to zero.
  always_ff @(posedge clk) begin
    if (advance) begin
      kind_r <= ctl.kind;
      last_r <= ctl.last;
      if (ctl.kind == vfqe_pkg::KIND_VERTEX) begin
        vx_r   <= {1'b0, cx_r} + 5'(corner[0]);
        vy_r   <= {1'b0, cy_r} + 9'(corner[1]);
        vz_r   <= {1'b0, cz_r} + 5'(corner[2]);
        u_r    <= corner[3];
        v_r    <= corner[4];
        fc_r   <= ctl.face;
        obid_r <= bid_r;
        idx_r  <= '0;
      end else begin
        vx_r   <= '0;
        vy_r   <= '0;
        vz_r   <= '0;
        u_r    <= 1'b0;
        v_r    <= 1'b0;
        fc_r   <= '0;
        obid_r <= '0;
        idx_r  <= {qc_r, 2'b00} + 21'(toff);
      end
    end
  end

  assign out_valid           = out_valid_r;
  assign out_record_kind     = kind_r;
  assign out_vert_x          = vx_r;
  assign out_vert_y          = vy_r;
  assign out_vert_z          = vz_r;
  assign out_face_code       = fc_r;
  assign out_tex_u           = u_r;
  assign out_tex_v           = v_r;
  assign out_vertex_block_id = obid_r;
  assign out_index_value     = idx_r;
  assign out_last_of_run     = last_r;

  // Final record of a run must release the sequencer.
  `VFQE_ASSERT(a_last_ends_run, clk, rst_n, (advance && ctl.last) |=> !ctl.busy, "last record left sequencer busy")
  // Run end only falls on an index record.
  `VFQE_NEVER(a_last_on_vertex, clk, rst_n, out_valid_r && last_r && (kind_r == vfqe_pkg::KIND_VERTEX), "last flag on vertex record")
  // Quad counter moves only at a face end or a chunk start.
  `VFQE_ASSERT(a_qc_moves, clk, rst_n, !$stable(qc_r) |-> ($past(advance && ctl.face_end) || $past(in_accept && in_chunk_start) || $past(!rst_n)), "quad counter changed unexpectedly")
  // A pending record is never overwritten by a new step.
  `VFQE_NEVER(a_no_overwrite, clk, rst_n, advance && out_valid_r && !out_ready, "output record overwritten")

endmodule

// ----- rtl/core/vfqe_sequencer.sv -----
// Microcode sequencer for the voxel face quad emitter: step counter,
// control ROM lookup, remaining-face mask and face-to-face jump.
// Depends on vfqe_pkg.
module vfqe_sequencer (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [vfqe_pkg::NUM_FACES-1:0] start_mask,
  input  logic                           advance,
  output vfqe_pkg::seq_ctl_t             ctl
);

  logic                           busy_r, busy_nxt;
  logic [vfqe_pkg::PC_W-1:0]      pc_r, pc_nxt;
  logic [vfqe_pkg::NUM_FACES-1:0] mask_r, mask_nxt;
  logic [2:0]                     face_r, face_nxt;

  vfqe_pkg::cw_t                  cw;
  logic [vfqe_pkg::NUM_FACES-1:0] rem;

  assign cw  = vfqe_pkg::ucode(pc_r);
  assign rem = mask_r & ~(vfqe_pkg::NUM_FACES'(1) << face_r);

  always_comb begin
    busy_nxt = busy_r;
    pc_nxt   = pc_r;
    mask_nxt = mask_r;
    face_nxt = face_r;
    if (start) begin
      busy_nxt = 1'b1;
      pc_nxt   = '0;
      mask_nxt = start_mask;
      face_nxt = vfqe_pkg::first_face(start_mask);
    end else if (advance) begin
      if (cw.jmp == vfqe_pkg::JMP_FACE) begin
        mask_nxt = rem;
        pc_nxt   = '0;
        face_nxt = vfqe_pkg::first_face(rem);
        if (rem == '0) busy_nxt = 1'b0;
      end else begin
        pc_nxt = pc_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pc_r   <= '0;
      mask_r <= '0;
      face_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      pc_r   <= pc_nxt;
      mask_r <= mask_nxt;
      face_r <= face_nxt;
    end
  end

  always_comb begin
    ctl.busy     = busy_r;
    ctl.kind     = cw.kind;
    ctl.sel      = cw.sel;
    ctl.face     = face_r;
    ctl.face_end = (cw.jmp == vfqe_pkg::JMP_FACE);
    ctl.last     = (cw.jmp == vfqe_pkg::JMP_FACE) && (rem == '0);
  end

endmodule
